// ===== rtl/mlhq_pkg.sv =====
// mlhq_pkg: shared types and constants for the multi-level hysteresis quantizer
// holds register indexes, sequencer state codes and level limits
// no dependencies
package mlhq_pkg;

    // highest number of levels the block is built for
    localparam int LEVELS    = 4;
    // level is two bits wide, so at most four levels exist
    localparam int MAX_COUNT = (LEVELS < 4) ? LEVELS : 4;

    localparam int SAMPLE_W = 32;
    localparam int LEVEL_W  = 2;
    localparam int COUNT_W  = 3;
    localparam int INDEX_W  = 3;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] REG_NUM_LEVELS  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_UP_1        = 3'd1;
    localparam logic [INDEX_W-1:0] REG_UP_2        = 3'd2;
    localparam logic [INDEX_W-1:0] REG_UP_3        = 3'd3;
    localparam logic [INDEX_W-1:0] REG_DOWN_1      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_DOWN_2      = 3'd5;
    localparam logic [INDEX_W-1:0] REG_DOWN_3      = 3'd6;

    // request kinds carried in tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FORCE  = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UP   = 4'b0010,
        ST_DOWN = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

// ===== rtl/multi_level_hysteresis_quantizer_core.sv =====
// multi_level_hysteresis_quantizer_core: level tracker with hysteresis
// uses one shared signed comparator under a four-state sequencer
// depends on mlhq_pkg
//
// Usage:
//   s_axis carries one request per beat. tuser is the request kind
//   (0 = sample, 1 = force level). tdata holds sample in [31:0] and
//   forced_level in [33:32], upper bits zero.
//   m_axis returns one beat per request: the level in tdata[1:0].
//   cfg_we/cfg_index/cfg_data write the level count and thresholds;
//   write only while no request is in flight.
// Timing:
//   a force request passes from the idle state to the finish state
//   and back to idle. A sample climbs in the up state, descends in the
//   down state if the first sample was already seen, then passes the
//   finish state; the shared comparator tests one threshold per cycle.
//   The result beat turns valid in the cycle s_axis_tready comes back high.
//   s_axis_tready is high only when the sequencer is idle; a new request
//   is taken while the previous result still waits in the output register.
// Reset: level 0, first sample not seen, level count 2, thresholds 0.
// Stall: a finished level waits in the sequencer until the output
//   register is free, so m_axis_tready low holds the block.
module multi_level_hysteresis_quantizer_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [39:0]                  s_axis_tdata,  // sample[31:0], forced_level[33:32]
    input  logic                         s_axis_tuser,  // req_type[0]
    // result channel
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // level[1:0]
    // configuration write port
    input  logic                         cfg_we,
    input  logic [mlhq_pkg::INDEX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data
);
    import mlhq_pkg::*;

    // configuration registers
    logic        [COUNT_W-1:0]  num_lvl_reg;
    logic signed [SAMPLE_W-1:0] up_thr_reg   [1:3];
    logic signed [SAMPLE_W-1:0] down_thr_reg [1:3];

    // block state
    logic [LEVEL_W-1:0] cur_level_reg, cur_level_next;
    logic               started_reg, started_next;

    // sequencer and work registers
    state_t                     state_reg, state_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [LEVEL_W-1:0]         lvl_reg, lvl_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;

    logic               in_fire;
    logic               out_free;
    logic [COUNT_W-1:0] count_lo;
    logic [COUNT_W-1:0] count_eff;
    logic [LEVEL_W-1:0] top_level;
    logic [LEVEL_W-1:0] forced_level;
    logic [LEVEL_W-1:0] up_idx;
    logic signed [SAMPLE_W-1:0] up_sel;
    logic signed [SAMPLE_W-1:0] down_sel;
    logic signed [SAMPLE_W-1:0] thr_sel;
    logic               cmp_lt;
    logic               cmp_eq;
    logic               can_climb;
    logic               can_descend;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lvl_reg <= 3'd2;
            for (int i = 1; i <= 3; i++)
            begin
                up_thr_reg[i]   <= '0;
                down_thr_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_LEVELS:  num_lvl_reg     <= cfg_data[COUNT_W-1:0];
                REG_UP_1:        up_thr_reg[1]   <= cfg_data;
                REG_UP_2:        up_thr_reg[2]   <= cfg_data;
                REG_UP_3:        up_thr_reg[3]   <= cfg_data;
                REG_DOWN_1:      down_thr_reg[1] <= cfg_data;
                REG_DOWN_2:      down_thr_reg[2] <= cfg_data;
                REG_DOWN_3:      down_thr_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // effective level count, clamped to 2..MAX_COUNT
    always_comb
    begin
        count_lo  = (num_lvl_reg < 3'd2) ? 3'd2 : num_lvl_reg;
        count_eff = (count_lo > COUNT_W'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT) : count_lo;
        top_level = LEVEL_W'(count_eff - 3'd1);
    end

    // threshold select for the shared comparator
    assign up_idx = lvl_reg + 2'd1;

    always_comb
    begin
        unique case (up_idx)
            2'd1:    up_sel = up_thr_reg[1];
            2'd2:    up_sel = up_thr_reg[2];
            2'd3:    up_sel = up_thr_reg[3];
            default: up_sel = '0;
        endcase
        unique case (lvl_reg)
            2'd1:    down_sel = down_thr_reg[1];
            2'd2:    down_sel = down_thr_reg[2];
            2'd3:    down_sel = down_thr_reg[3];
            default: down_sel = '0;
        endcase
    end

    assign thr_sel = (state_reg == ST_DOWN) ? down_sel : up_sel;

    // shared signed comparator
    assign cmp_lt = (sample_reg < thr_sel);
    assign cmp_eq = (sample_reg == thr_sel);

    assign can_climb   = (lvl_reg < top_level) && !cmp_lt;
    assign can_descend = (lvl_reg != 2'd0) && (cmp_lt || cmp_eq);

    // handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign forced_level  = s_axis_tdata[33:32];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        lvl_next       = lvl_reg;
        cur_level_next = cur_level_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_level_next = out_level_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next = s_axis_tdata[SAMPLE_W-1:0];
                    if (s_axis_tuser == REQ_FORCE)
                    begin
                        lvl_next   = (forced_level > top_level) ? top_level : forced_level;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        lvl_next   = started_reg ? cur_level_reg : 2'd0;
                        state_next = ST_UP;
                    end
                end
            end
            ST_UP:
            begin
                // climb one level per cycle, then descend if already started
                if (can_climb)
                    lvl_next = lvl_reg + 2'd1;
                else if (started_reg)
                    state_next = ST_DOWN;
                else
                    state_next = ST_FIN;
            end
            ST_DOWN:
            begin
                if (can_descend)
                    lvl_next = lvl_reg - 2'd1;
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // commit once the output register can take the beat
                if (out_free)
                begin
                    cur_level_next = lvl_reg;
                    started_next   = 1'b1;
                    out_valid_next = 1'b1;
                    out_level_next = lvl_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_level_reg <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_level_reg <= cur_level_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        out_level_reg <= out_level_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_level_reg};

endmodule
